// File: sv/atomic_memory_op_unit_top_defines.svh
// ----------------------------------------------------------------------------
// Atomic memory op unit - assertion macros
// Shared concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ATOMIC_MEMORY_OP_UNIT_TOP_DEFINES_SVH
`define ATOMIC_MEMORY_OP_UNIT_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Clocked assertion, disabled while reset is asserted
`define AMO_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Clocked assertion, checked during reset too
`define AMO_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define AMO_ASSERT(lbl, clk, rstn, prop, msg)
`define AMO_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: sv/amo_pkg.sv
// ----------------------------------------------------------------------------
// Atomic memory op unit - package
// Sizes, codes, item and control types shared by the unit's modules.
// ----------------------------------------------------------------------------
package amo_pkg;

    // Local memory geometry: eight byte-wide banks, one per byte lane
    localparam int MEM_BYTES  = 4096;
    localparam int LANES      = 8;
    localparam int ROWS       = (MEM_BYTES + LANES - 1) / LANES;
    localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int ADDR_W     = 12;
    localparam int DATA_W     = 64;
    localparam int END_RAW_W  = $clog2(MEM_BYTES + LANES) + 1;
    localparam int END_W      = (END_RAW_W > ADDR_W + 1) ? END_RAW_W : ADDR_W + 1;

    // Stream widths, padded to whole bytes
    localparam int S_TDATA_W  = 152;
    localparam int M_TDATA_W  = 72;

    // Commands
    localparam logic CMD_RMW = 1'b0;
    localparam logic CMD_CAS = 1'b1;

    // Read-modify-write opcodes
    localparam logic [3:0] OP_ADD  = 4'd0;
    localparam logic [3:0] OP_CLR  = 4'd1;
    localparam logic [3:0] OP_XOR  = 4'd2;
    localparam logic [3:0] OP_SET  = 4'd3;
    localparam logic [3:0] OP_SMAX = 4'd4;
    localparam logic [3:0] OP_SMIN = 4'd5;
    localparam logic [3:0] OP_UMAX = 4'd6;
    localparam logic [3:0] OP_UMIN = 4'd7;
    localparam logic [3:0] OP_SWAP = 4'd8;

    // Result status
    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_FAULT = 2'd1,
        STAT_UNSUP = 2'd2
    } status_t;

    // Controller states
    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // One input item
    typedef struct packed {
        logic                command;
        logic [1:0]          access_size;
        logic [3:0]          rmw_op;
        logic [ADDR_W-1:0]   address;
        logic [DATA_W-1:0]   operand;
        logic [DATA_W-1:0]   expected;
    } in_item_t;

    // Controller to datapath
    typedef struct packed {
        logic ready;    // input channel open
        logic accept;   // input beat taken this cycle
        logic exec;     // execute and write back this cycle
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free; // output register can take a result this cycle
    } dp_status_t;

    // Byte count minus nothing: 1, 2, 4 or 8
    function automatic logic [3:0] size_bytes(input logic [1:0] size);
        return 4'd1 << size;
    endfunction

    // Mask of the accessed bits
    function automatic logic [DATA_W-1:0] size_mask(input logic [1:0] size);
        logic [DATA_W-1:0] m;
        unique case (size)
            2'd0: m = 64'h0000_0000_0000_00ff;
            2'd1: m = 64'h0000_0000_0000_ffff;
            2'd2: m = 64'h0000_0000_ffff_ffff;
            default: m = 64'hffff_ffff_ffff_ffff;
        endcase
        return m;
    endfunction

    // Sign bit of the access width
    function automatic logic [DATA_W-1:0] size_sign(input logic [1:0] size);
        logic [DATA_W-1:0] s;
        unique case (size)
            2'd0: s = 64'h0000_0000_0000_0080;
            2'd1: s = 64'h0000_0000_0000_8000;
            2'd2: s = 64'h0000_0000_8000_0000;
            default: s = 64'h8000_0000_0000_0000;
        endcase
        return s;
    endfunction

endpackage

// File: sv/amo_byte_bank.sv
// ----------------------------------------------------------------------------
// Atomic memory op unit - byte bank
// One byte lane of local memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module amo_byte_bank (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [amo_pkg::ROW_W-1:0] waddr,
    input  logic [7:0]               wdata,
    input  logic                     re,
    input  logic [amo_pkg::ROW_W-1:0] raddr,
    output logic [7:0]               rdata
);
    import amo_pkg::*;

    logic [7:0] mem [ROWS];
    logic [7:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/amo_ctrl.sv
// ----------------------------------------------------------------------------
// Atomic memory op unit - controller
// Two-state sequencer: take a beat and read, then execute and write back.
// ----------------------------------------------------------------------------
module amo_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  amo_pkg::dp_status_t status,
    output amo_pkg::ctrl_cmd_t  cmd
);
    import amo_pkg::*;

    state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (status.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.ready  = 1'b1;
                cmd.accept = s_tvalid;
            end
            ST_EXEC: begin
                cmd.exec = status.out_free;
            end
            default: cmd = '0;
        endcase
    end

endmodule

// File: sv/amo_datapath.sv
// ----------------------------------------------------------------------------
// Atomic memory op unit - datapath
// Item registers, banked memory, lane steering, ALU and output register.
// ----------------------------------------------------------------------------
module amo_datapath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  amo_pkg::in_item_t           s_item,
    input  amo_pkg::ctrl_cmd_t          cmd,
    output amo_pkg::dp_status_t         status,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [amo_pkg::DATA_W-1:0]  m_old_value,
    output amo_pkg::status_t            m_status
);
    import amo_pkg::*;

    `include "atomic_memory_op_unit_top_defines.svh"

    in_item_t          item_reg;
    logic              out_valid_reg;
    logic [DATA_W-1:0] old_value_reg;
    status_t           status_reg;

    logic [ROW_W-1:0]  rd_row   [LANES];
    logic [ROW_W-1:0]  wr_row   [LANES];
    logic [7:0]        rd_byte  [LANES];
    logic [7:0]        wr_byte  [LANES];
    logic [LANES-1:0]  wr_en;

    logic [2:0]        lo;
    logic [3:0]        nbytes;
    logic [DATA_W-1:0] mask, sign;
    logic [DATA_W-1:0] old_raw, old_val, opnd, expv, cmp_a, cmp_b, new_val;
    logic              lt, fault, unsup, do_write;
    logic [END_W-1:0]  end_addr;
    status_t           res_status;

    // Item register, loaded with each accepted beat
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            item_reg <= s_item;
        end
    end

    // Per-lane rows: lanes below the start offset sit in the next row
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            rd_row[k] = ROW_W'(s_item.address >> 3)
                        + ROW_W'(3'(k) < s_item.address[2:0]);
            wr_row[k] = ROW_W'(item_reg.address >> 3)
                        + ROW_W'(3'(k) < item_reg.address[2:0]);
        end
    end

    // Byte banks
    for (genvar g = 0; g < LANES; g++) begin : g_bank
        amo_byte_bank u_bank (
            .aclk  (aclk),
            .we    (wr_en[g]),
            .waddr (wr_row[g]),
            .wdata (wr_byte[g]),
            .re    (cmd.accept),
            .raddr (rd_row[g]),
            .rdata (rd_byte[g])
        );
    end

    // Size decode and bounds check
    assign lo       = item_reg.address[2:0];
    assign nbytes   = size_bytes(item_reg.access_size);
    assign mask     = size_mask(item_reg.access_size);
    assign sign     = size_sign(item_reg.access_size);
    assign end_addr = END_W'(item_reg.address) + END_W'(nbytes);
    assign fault    = end_addr > END_W'(MEM_BYTES);
    assign unsup    = (item_reg.command == CMD_RMW) && (item_reg.rmw_op > OP_SWAP);

    // Gather old value from the rotated lanes
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            old_raw[8*i +: 8] = rd_byte[3'(lo + 3'(i))];
        end
    end

    assign old_val = old_raw & mask;
    assign opnd    = item_reg.operand & mask;
    assign expv    = item_reg.expected & mask;

    // Shared magnitude compare; signed ops bias the sign bit
    always_comb begin
        if (item_reg.rmw_op == OP_SMAX || item_reg.rmw_op == OP_SMIN) begin
            cmp_a = old_val ^ sign;
            cmp_b = opnd ^ sign;
        end else begin
            cmp_a = old_val;
            cmp_b = opnd;
        end
    end
    assign lt = cmp_a < cmp_b;

    // New value
    always_comb begin
        unique case (item_reg.rmw_op)
            OP_ADD:  new_val = (old_val + opnd) & mask;
            OP_CLR:  new_val = old_val & ~opnd;
            OP_XOR:  new_val = old_val ^ opnd;
            OP_SET:  new_val = old_val | opnd;
            OP_SMAX: new_val = lt ? opnd : old_val;
            OP_SMIN: new_val = lt ? old_val : opnd;
            OP_UMAX: new_val = lt ? opnd : old_val;
            OP_UMIN: new_val = lt ? old_val : opnd;
            default: new_val = opnd;
        endcase
        if (item_reg.command == CMD_CAS) new_val = opnd;
    end

    // Result status; compare mismatch on CAS only suppresses the write
    always_comb begin
        priority if (fault) begin
            res_status = STAT_FAULT;
        end else if (unsup) begin
            res_status = STAT_UNSUP;
        end else begin
            res_status = STAT_DONE;
        end
    end

    assign do_write = cmd.exec && (res_status == STAT_DONE)
                      && ((item_reg.command == CMD_RMW) || (old_val == expv));

    // Scatter write data back to lanes
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            wr_byte[k] = new_val[8*(3'(3'(k) - lo)) +: 8];
            wr_en[k]   = do_write && ({1'b0, 3'(3'(k) - lo)} < nbytes);
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.exec) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            old_value_reg <= (res_status == STAT_DONE) ? old_val : '0;
            status_reg    <= res_status;
        end
    end

    assign status.out_free = !out_valid_reg || m_tready;
    assign m_tvalid        = out_valid_reg;
    assign m_old_value     = old_value_reg;
    assign m_status        = status_reg;

    // Checks
    `AMO_ASSERT(a_no_write_on_error, aclk, aresetn, (|wr_en) |-> (res_status == STAT_DONE), "memory written on a failed item")
    `AMO_ASSERT(a_write_lane_count, aclk, aresetn, (|wr_en) |-> ($countones(wr_en) == int'(nbytes)), "write lane count differs from access size")
    `AMO_ASSERT(a_exec_needs_room, aclk, aresetn, cmd.exec |-> (!out_valid_reg || m_tready), "result dropped over a waiting result")
    `AMO_ASSERT(a_error_zero_value, aclk, aresetn, (m_tvalid && (m_status != STAT_DONE)) |-> (m_old_value == '0), "error result carries a nonzero value")

endmodule

// File: sv/atomic_memory_op_unit_top.sv
// ----------------------------------------------------------------------------
// Atomic memory op unit - top level
// Stream wrapper around the controller and the banked-memory datapath.
// ----------------------------------------------------------------------------
// Each beat is one atomic read-modify-write or compare-and-swap of 1, 2, 4 or
// 8 bytes at any byte address of a 4096-byte little-endian local memory, and
// gives exactly one result beat. In the accept cycle all eight byte-lane banks
// are read at once; in the execute state the ALU works on the old value and
// writes back through the same banks' write ports. The result waits in an
// output register, and the next beat is taken in the cycle after execution,
// so a new item is not taken until the previous one has executed; an item
// waits in the execute cycle while the previous result is still untaken.
// A fault or unsupported opcode writes nothing and returns zero. Memory is
// not cleared after reset: a byte must be written before it is read.
// ----------------------------------------------------------------------------
module atomic_memory_op_unit_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    // command[0], access_size[2:1], rmw_op[6:3], address[18:7],
    // operand[82:19], expected[146:83], zero pad
    input  logic [amo_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // old_value[63:0], status[65:64], zero pad
    output logic [amo_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready
);
    import amo_pkg::*;

    in_item_t          s_item;
    ctrl_cmd_t         cmd;
    dp_status_t        status;
    logic [DATA_W-1:0] old_value;
    status_t           res_status;

    // Unpack the input beat
    assign s_item.command     = s_tdata[0];
    assign s_item.access_size = s_tdata[2:1];
    assign s_item.rmw_op      = s_tdata[6:3];
    assign s_item.address     = s_tdata[18:7];
    assign s_item.operand     = s_tdata[82:19];
    assign s_item.expected    = s_tdata[146:83];

    amo_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .status   (status),
        .cmd      (cmd)
    );

    amo_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_item      (s_item),
        .cmd         (cmd),
        .status      (status),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_old_value (old_value),
        .m_status    (res_status)
    );

    assign s_tready = cmd.ready;

    // Pack the result beat
    assign m_tdata = {(M_TDATA_W - DATA_W - 2)'(0), res_status, old_value};

endmodule
